// ===== rtl/core/tobp_pkg.sv =====
// Shared constants, codes and types for the tree object byte parser.
`timescale 1ns / 1ps
`default_nettype none

package tobp_pkg;

    // Format limits of a tree object.
    localparam int MAX_ENTRIES = 1024;
    localparam int HASH_BYTES  = 32;
    localparam int NAME_LIMIT  = 256;
    localparam int MODE_LIMIT  = 16;

    // Counter widths that follow from the limits.
    localparam int MODE_CNT_W  = $clog2(MODE_LIMIT + 1);
    localparam int NAME_CNT_W  = $clog2(NAME_LIMIT);
    localparam int HASH_CNT_W  = $clog2(HASH_BYTES + 1);
    localparam int ENTRY_CNT_W = $clog2(MAX_ENTRIES + 1);

    // Fixed widths of the stream fields.
    localparam int IN_DATA_W   = 8;
    localparam int KIND_W      = 3;
    localparam int ENTRY_NUM_W = 10;
    localparam int OFFSET_W    = 8;
    localparam int PAYLOAD_W   = 8;
    localparam int MODE_W      = 32;
    localparam int TOTAL_W     = 11;
    localparam int OUT_FIELD_W = ENTRY_NUM_W + OFFSET_W + PAYLOAD_W + MODE_W + TOTAL_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Byte values of the object syntax.
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_SEVEN = 8'h37;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_NAME_BYTE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NAME_END  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HASH_BYTE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PARSE_OK  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PARSE_ERR = 3'd4;

    // Field being parsed.
    localparam logic [1:0] PH_MODE = 2'd0;
    localparam logic [1:0] PH_NAME = 2'd1;
    localparam logic [1:0] PH_HASH = 2'd2;

    // Run state of the current object.
    localparam logic [1:0] HK_RUN  = 2'd0;
    localparam logic [1:0] HK_DONE = 2'd1;
    localparam logic [1:0] HK_ERR  = 2'd2;

    // One result as held in the queue.
    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [ENTRY_NUM_W-1:0] entry_number;
        logic [OFFSET_W-1:0]    byte_offset;
        logic [PAYLOAD_W-1:0]   payload;
        logic [MODE_W-1:0]      mode_value;
        logic [TOTAL_W-1:0]     entries_total;
        logic                   run_end;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/tree_object_byte_parser_top.sv =====
// Top level of the tree object byte parser: entry field tracking and result queue.
`timescale 1ns / 1ps
`default_nettype none

// A result is written into the result queue when its byte is accepted and is offered on the master side from there.
// Throughput: one byte per cycle while the slave side is ready; the final byte of an object gives
// up to two results, the status behind any data result, through a four-entry result queue.
// The slave side is ready while the queue holds at most two results.
// Reset (synchronous, active low) clears the parse state and empties the queue.
module tree_object_byte_parser_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] in_byte
    input  wire  [tobp_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    input  wire                                i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // [9:0] entry_number, [17:10] byte_offset, [25:18] payload,
    // [57:26] mode_value, [68:58] entries_total, [71:69] zero
    output logic [tobp_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // [2:0] kind
    output logic [tobp_pkg::KIND_W-1:0]        o_m_axis_tuser,
    output logic                               o_m_axis_tlast
);

    // Parse state.
    logic [1:0]                         r_phase,     n_phase;
    logic [31:0]                        r_mode_acc,  n_mode_acc;
    logic [tobp_pkg::MODE_CNT_W-1:0]    r_mode_cnt,  n_mode_cnt;
    logic                               r_mode_stop, n_mode_stop;
    logic [tobp_pkg::NAME_CNT_W-1:0]    r_name_cnt,  n_name_cnt;
    logic [tobp_pkg::HASH_CNT_W-1:0]    r_hash_cnt,  n_hash_cnt;
    logic [tobp_pkg::ENTRY_CNT_W-1:0]   r_entry_cnt, n_entry_cnt;
    logic [1:0]                         r_halt,      n_halt;

    // Result queue.
    tobp_pkg::t_result                  r_queue [tobp_pkg::QUEUE_DEPTH];
    logic [tobp_pkg::QUEUE_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [tobp_pkg::QUEUE_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [tobp_pkg::QUEUE_CNT_W-1:0]   r_count,  n_count;

    logic                               in_accept;
    logic                               out_accept;
    logic [7:0]                         in_byte;
    logic                               data_vld;
    logic                               stat_vld;
    tobp_pkg::t_result                  data_res;
    tobp_pkg::t_result                  stat_res;
    logic                               parse_ok;
    logic [tobp_pkg::QUEUE_PTR_W-1:0]   stat_slot;
    tobp_pkg::t_result                  head;

    assign in_byte    = i_s_axis_tdata;
    assign in_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_accept = o_m_axis_tvalid && i_m_axis_tready;

    // Room for the two results that a final byte can cause.
    assign o_s_axis_tready = (r_count <= tobp_pkg::QUEUE_CNT_W'(tobp_pkg::QUEUE_DEPTH - 2));

    // Per-byte parse step: next state and up to two results.
    always_comb begin
        n_phase     = r_phase;
        n_mode_acc  = r_mode_acc;
        n_mode_cnt  = r_mode_cnt;
        n_mode_stop = r_mode_stop;
        n_name_cnt  = r_name_cnt;
        n_hash_cnt  = r_hash_cnt;
        n_entry_cnt = r_entry_cnt;
        n_halt      = r_halt;
        data_vld    = 1'b0;
        stat_vld    = 1'b0;
        parse_ok    = 1'b0;
        data_res    = '0;
        stat_res    = '0;
        data_res.entry_number = tobp_pkg::ENTRY_NUM_W'(r_entry_cnt);

        if (in_accept) begin
            if (r_halt == tobp_pkg::HK_RUN) begin
                unique case (r_phase)
                    tobp_pkg::PH_MODE: begin
                        if (in_byte == tobp_pkg::BYTE_SPACE) begin
                            n_phase    = tobp_pkg::PH_NAME;
                            n_name_cnt = '0;
                        end else begin
                            n_mode_cnt = r_mode_cnt + 1'b1;
                            if ((int'(r_mode_cnt) + 1) >= tobp_pkg::MODE_LIMIT) begin
                                n_halt = tobp_pkg::HK_ERR;
                            end else if (!r_mode_stop && in_byte >= tobp_pkg::BYTE_ZERO &&
                                         in_byte <= tobp_pkg::BYTE_SEVEN) begin
                                n_mode_acc = {r_mode_acc[28:0], in_byte[2:0]};
                            end else begin
                                n_mode_stop = 1'b1;
                            end
                        end
                    end
                    tobp_pkg::PH_NAME: begin
                        if (in_byte == tobp_pkg::BYTE_NUL) begin
                            data_vld            = 1'b1;
                            data_res.kind       = tobp_pkg::KIND_NAME_END;
                            data_res.mode_value = r_mode_acc;
                            n_phase             = tobp_pkg::PH_HASH;
                            n_hash_cnt          = '0;
                        end else if ((int'(r_name_cnt) + 1) >= tobp_pkg::NAME_LIMIT) begin
                            n_halt = tobp_pkg::HK_ERR;
                        end else begin
                            data_vld             = 1'b1;
                            data_res.kind        = tobp_pkg::KIND_NAME_BYTE;
                            data_res.byte_offset = tobp_pkg::OFFSET_W'(r_name_cnt);
                            data_res.payload     = in_byte;
                            n_name_cnt           = r_name_cnt + 1'b1;
                        end
                    end
                    tobp_pkg::PH_HASH: begin
                        data_vld             = 1'b1;
                        data_res.kind        = tobp_pkg::KIND_HASH_BYTE;
                        data_res.byte_offset = tobp_pkg::OFFSET_W'(r_hash_cnt);
                        data_res.payload     = in_byte;
                        if ((int'(r_hash_cnt) + 1) >= tobp_pkg::HASH_BYTES) begin
                            // Entry complete: back to the mode field of the next one.
                            n_entry_cnt = r_entry_cnt + 1'b1;
                            n_phase     = tobp_pkg::PH_MODE;
                            n_mode_acc  = '0;
                            n_mode_cnt  = '0;
                            n_mode_stop = 1'b0;
                            n_name_cnt  = '0;
                            n_hash_cnt  = '0;
                            if ((int'(r_entry_cnt) + 1) >= tobp_pkg::MAX_ENTRIES) begin
                                n_halt = tobp_pkg::HK_DONE;
                            end
                        end else begin
                            n_hash_cnt = r_hash_cnt + 1'b1;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end

            // The final byte reports status and returns the parse state to its reset values.
            if (i_s_axis_tlast) begin
                parse_ok = (n_halt == tobp_pkg::HK_DONE) ||
                           (n_halt == tobp_pkg::HK_RUN && n_phase == tobp_pkg::PH_MODE &&
                            n_mode_cnt == '0);
                stat_vld               = 1'b1;
                stat_res.kind          = parse_ok ? tobp_pkg::KIND_PARSE_OK
                                                  : tobp_pkg::KIND_PARSE_ERR;
                stat_res.entry_number  = tobp_pkg::ENTRY_NUM_W'(n_entry_cnt);
                stat_res.entries_total = tobp_pkg::TOTAL_W'(n_entry_cnt);
                stat_res.run_end       = 1'b1;
                n_phase     = tobp_pkg::PH_MODE;
                n_mode_acc  = '0;
                n_mode_cnt  = '0;
                n_mode_stop = 1'b0;
                n_name_cnt  = '0;
                n_hash_cnt  = '0;
                n_entry_cnt = '0;
                n_halt      = tobp_pkg::HK_RUN;
            end
        end
        data_res.run_end = !stat_vld;
    end

    // Queue pointers: the status result goes in behind the data result.
    assign stat_slot = r_wr_ptr + tobp_pkg::QUEUE_PTR_W'(data_vld);

    always_comb begin
        n_wr_ptr = r_wr_ptr + tobp_pkg::QUEUE_PTR_W'(data_vld) +
                   tobp_pkg::QUEUE_PTR_W'(stat_vld);
        n_rd_ptr = r_rd_ptr + tobp_pkg::QUEUE_PTR_W'(out_accept);
        n_count  = r_count + tobp_pkg::QUEUE_CNT_W'(data_vld) +
                   tobp_pkg::QUEUE_CNT_W'(stat_vld) - tobp_pkg::QUEUE_CNT_W'(out_accept);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tobp_pkg::PH_MODE;
            r_mode_acc  <= '0;
            r_mode_cnt  <= '0;
            r_mode_stop <= 1'b0;
            r_name_cnt  <= '0;
            r_hash_cnt  <= '0;
            r_entry_cnt <= '0;
            r_halt      <= tobp_pkg::HK_RUN;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            r_phase     <= n_phase;
            r_mode_acc  <= n_mode_acc;
            r_mode_cnt  <= n_mode_cnt;
            r_mode_stop <= n_mode_stop;
            r_name_cnt  <= n_name_cnt;
            r_hash_cnt  <= n_hash_cnt;
            r_entry_cnt <= n_entry_cnt;
            r_halt      <= n_halt;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_count     <= n_count;
        end
    end

    // Queue storage: each slot takes the data or the status result.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < tobp_pkg::QUEUE_DEPTH; i++) begin
            if (data_vld && r_wr_ptr == tobp_pkg::QUEUE_PTR_W'(i)) begin
                r_queue[i] <= data_res;
            end else if (stat_vld && stat_slot == tobp_pkg::QUEUE_PTR_W'(i)) begin
                r_queue[i] <= stat_res;
            end
        end
    end

    // Master side shows the queue head.
    assign head            = r_queue[r_rd_ptr];
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tuser  = head.kind;
    assign o_m_axis_tlast  = head.run_end;
    assign o_m_axis_tdata  = {{tobp_pkg::OUT_PAD_W{1'b0}}, head.entries_total,
                              head.mode_value, head.payload, head.byte_offset,
                              head.entry_number};

endmodule

`default_nettype wire

// ===== rtl/core/tobp_checker.sv =====
// Port-level checks of the tree object byte parser, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module tobp_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_s_axis_tvalid,
    input wire                              o_s_axis_tready,
    input wire                              i_s_axis_tlast,
    input wire                              o_m_axis_tvalid,
    input wire                              i_m_axis_tready,
    input wire [tobp_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input wire [tobp_pkg::KIND_W-1:0]       o_m_axis_tuser,
    input wire                              o_m_axis_tlast
);

    // A status result always closes the run of its request.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == tobp_pkg::KIND_PARSE_OK ||
                            o_m_axis_tuser == tobp_pkg::KIND_PARSE_ERR)
        |-> o_m_axis_tlast)
        else $error("status result without tlast");

    // Only a name end carries a mode value.
    a_mode_only_name_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != tobp_pkg::KIND_NAME_END
        |-> o_m_axis_tdata[57:26] == 32'd0)
        else $error("mode value on a result other than name end");

    // Data results carry no entry total.
    a_bytes_no_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == tobp_pkg::KIND_NAME_BYTE ||
                            o_m_axis_tuser == tobp_pkg::KIND_HASH_BYTE ||
                            o_m_axis_tuser == tobp_pkg::KIND_NAME_END)
        |-> o_m_axis_tdata[68:58] == 11'd0)
        else $error("entry total on a data result");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // An accepted final byte always leaves a result waiting on the master side.
    a_final_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast
        |=> o_m_axis_tvalid)
        else $error("final request without a pending result");

endmodule

bind tree_object_byte_parser_top tobp_checker u_tobp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

// ===== sim/tb_tree_object_byte_parser_top.sv =====
// Self-checking testbench for the tree object byte parser top level.
`timescale 1ns / 1ps

module tb_tree_object_byte_parser_top;

    // Run limits: the timeout covers the whole stimulus with heavy stalls on both sides.
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TOTAL_ITEMS  = 950;

    // Bit positions of the result fields within tdata.
    localparam int ENT_LSB  = 0;
    localparam int OFF_LSB  = ENT_LSB + tobp_pkg::ENTRY_NUM_W;
    localparam int PAY_LSB  = OFF_LSB + tobp_pkg::OFFSET_W;
    localparam int MODE_LSB = PAY_LSB + tobp_pkg::PAYLOAD_W;
    localparam int TOT_LSB  = MODE_LSB + tobp_pkg::MODE_W;

    // One byte request waiting to be offered on the slave side.
    typedef struct packed {
        logic [tobp_pkg::IN_DATA_W-1:0] data;
        logic                           fin;
    } t_byte_req;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [tobp_pkg::IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                            i_s_axis_tlast = 1'b0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [tobp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [tobp_pkg::KIND_W-1:0]     o_m_axis_tuser;
    logic                            o_m_axis_tlast;

    t_byte_req         pending_bytes[$];
    tobp_pkg::t_result expected_results[$];
    int                mismatch_cnt = 0;
    int                results_seen = 0;
    int                cycle_cnt = 0;

    // Parser state tracked alongside the block.
    logic [1:0]                  ph;
    logic [tobp_pkg::MODE_W-1:0] mode_acc;
    logic [4:0]                  mode_cnt;
    logic                        mode_halted;
    logic [8:0]                  name_cnt;
    logic [5:0]                  hash_cnt;
    logic [10:0]                 entry_cnt;
    logic [1:0]                  run_state;

    tree_object_byte_parser_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Return the tracked parser state to its reset values.
    function automatic void clear_parse();
        ph          = tobp_pkg::PH_MODE;
        mode_acc    = '0;
        mode_cnt    = '0;
        mode_halted = 1'b0;
        name_cnt    = '0;
        hash_cnt    = '0;
        entry_cnt   = '0;
        run_state   = tobp_pkg::HK_RUN;
    endfunction

    // Queue one expected result tagged with the current entry number.
    function automatic void emit_result(input logic [tobp_pkg::KIND_W-1:0] kind,
                                        input logic [tobp_pkg::OFFSET_W-1:0] off,
                                        input logic [tobp_pkg::PAYLOAD_W-1:0] pay,
                                        input logic [tobp_pkg::MODE_W-1:0] mode,
                                        input logic [tobp_pkg::TOTAL_W-1:0] total);
        tobp_pkg::t_result r;
        r.kind          = kind;
        r.entry_number  = entry_cnt[tobp_pkg::ENTRY_NUM_W-1:0];
        r.byte_offset   = off;
        r.payload       = pay;
        r.mode_value    = mode;
        r.entries_total = total;
        r.run_end       = 1'b0;
        expected_results.push_back(r);
    endfunction

    // Advance the tracked parser by one accepted byte and queue what it yields.
    function automatic void parse_byte(input logic [tobp_pkg::IN_DATA_W-1:0] b,
                                       input logic fin);
        int   n_before;
        logic ok;
        n_before = expected_results.size();
        if (run_state == tobp_pkg::HK_RUN) begin
            case (ph)
                tobp_pkg::PH_MODE: begin
                    if (b == tobp_pkg::BYTE_SPACE) begin
                        ph       = tobp_pkg::PH_NAME;
                        name_cnt = '0;
                    end else begin
                        mode_cnt = mode_cnt + 1'b1;
                        if (mode_cnt >= tobp_pkg::MODE_LIMIT) begin
                            run_state = tobp_pkg::HK_ERR;
                        end else if (!mode_halted && b >= tobp_pkg::BYTE_ZERO &&
                                     b <= tobp_pkg::BYTE_SEVEN) begin
                            mode_acc = (mode_acc << 3) +
                                       tobp_pkg::MODE_W'(b - tobp_pkg::BYTE_ZERO);
                        end else begin
                            mode_halted = 1'b1;
                        end
                    end
                end
                tobp_pkg::PH_NAME: begin
                    if (b == tobp_pkg::BYTE_NUL) begin
                        emit_result(tobp_pkg::KIND_NAME_END, '0, '0, mode_acc, '0);
                        ph       = tobp_pkg::PH_HASH;
                        hash_cnt = '0;
                    end else if (int'(name_cnt) + 1 >= tobp_pkg::NAME_LIMIT) begin
                        run_state = tobp_pkg::HK_ERR;
                    end else begin
                        emit_result(tobp_pkg::KIND_NAME_BYTE,
                                    name_cnt[tobp_pkg::OFFSET_W-1:0], b, '0, '0);
                        name_cnt = name_cnt + 1'b1;
                    end
                end
                default: begin
                    emit_result(tobp_pkg::KIND_HASH_BYTE, tobp_pkg::OFFSET_W'(hash_cnt),
                                b, '0, '0);
                    hash_cnt = hash_cnt + 1'b1;
                    if (hash_cnt >= tobp_pkg::HASH_BYTES) begin
                        entry_cnt   = entry_cnt + 1'b1;
                        ph          = tobp_pkg::PH_MODE;
                        mode_acc    = '0;
                        mode_cnt    = '0;
                        mode_halted = 1'b0;
                        name_cnt    = '0;
                        hash_cnt    = '0;
                        if (entry_cnt >= tobp_pkg::MAX_ENTRIES)
                            run_state = tobp_pkg::HK_DONE;
                    end
                end
            endcase
        end
        // The status of the object follows any data result of the final byte.
        if (fin) begin
            if (run_state == tobp_pkg::HK_ERR)
                ok = 1'b0;
            else if (run_state == tobp_pkg::HK_DONE)
                ok = 1'b1;
            else
                ok = (ph == tobp_pkg::PH_MODE) && (mode_cnt == 0);
            emit_result(ok ? tobp_pkg::KIND_PARSE_OK : tobp_pkg::KIND_PARSE_ERR,
                        '0, '0, '0, entry_cnt);
            clear_parse();
        end
        if (expected_results.size() > n_before)
            expected_results[expected_results.size() - 1].run_end = 1'b1;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string field,
                                   input logic [tobp_pkg::MODE_W-1:0] seen,
                                   input logic [tobp_pkg::MODE_W-1:0] want);
        $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
                 results_seen, field, seen, want);
        mismatch_cnt++;
    endtask

    // Stimulus helpers that append byte requests to the pending queue.
    function automatic void add_byte(input logic [tobp_pkg::IN_DATA_W-1:0] b,
                                     input logic fin);
        t_byte_req req;
        req.data = b;
        req.fin  = fin;
        pending_bytes.push_back(req);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], 1'b0);
    endfunction

    function automatic void add_hash(input logic fin_last);
        for (int i = 0; i < tobp_pkg::HASH_BYTES; i++)
            add_byte(tobp_pkg::IN_DATA_W'($urandom_range(0, 255)),
                     fin_last && (i == tobp_pkg::HASH_BYTES - 1));
    endfunction

    // One entry with random content; a non-octal mode mixes in arbitrary bytes.
    function automatic void add_entry(input int n_mode, input logic octal, input int n_name,
                                      input logic fin_last);
        logic [tobp_pkg::IN_DATA_W-1:0] b;
        for (int i = 0; i < n_mode; i++) begin
            if (octal || $urandom_range(0, 3) != 0) begin
                b = tobp_pkg::BYTE_ZERO + tobp_pkg::IN_DATA_W'($urandom_range(0, 7));
            end else begin
                b = tobp_pkg::IN_DATA_W'($urandom_range(0, 255));
                if (b == tobp_pkg::BYTE_SPACE)
                    b = 8'h39;
            end
            add_byte(b, 1'b0);
        end
        add_byte(tobp_pkg::BYTE_SPACE, 1'b0);
        for (int i = 0; i < n_name; i++)
            add_byte(tobp_pkg::IN_DATA_W'($urandom_range(1, 255)), 1'b0);
        add_byte(tobp_pkg::BYTE_NUL, 1'b0);
        add_hash(fin_last);
    endfunction

    // Build the whole stimulus, run reset, then wait for every result to drain.
    initial begin
        int mark;
        int cut;
        int n;
        int sel;
        clear_parse();

        // Lone final bytes: a zero byte in the mode and a space that opens a name.
        add_byte(tobp_pkg::BYTE_NUL, 1'b1);
        add_byte(tobp_pkg::BYTE_SPACE, 1'b1);
        // A plain file entry that ends the object cleanly.
        add_text("100644 f");
        add_byte(tobp_pkg::BYTE_NUL, 1'b0);
        add_hash(1'b1);
        // Longest legal mode, which wraps the 32-bit value, and the longest legal name.
        for (int i = 0; i < tobp_pkg::MODE_LIMIT - 1; i++)
            add_byte(tobp_pkg::BYTE_SEVEN, 1'b0);
        add_byte(tobp_pkg::BYTE_SPACE, 1'b0);
        for (int i = 0; i < tobp_pkg::NAME_LIMIT - 1; i++)
            add_byte(8'hFF, 1'b0);
        add_byte(tobp_pkg::BYTE_NUL, 1'b0);
        for (int i = 0; i < tobp_pkg::HASH_BYTES; i++)
            add_byte(i[0] ? 8'hFF : 8'h00, i == tobp_pkg::HASH_BYTES - 1);
        // Mode too long, then bytes that the halted parser ignores.
        for (int i = 0; i < tobp_pkg::MODE_LIMIT; i++)
            add_byte(8'h31, 1'b0);
        add_text(" x");
        add_byte(tobp_pkg::BYTE_NUL, 1'b0);
        add_byte(8'h41, 1'b1);
        // Name too long, then ignored bytes.
        add_text("40000 ");
        for (int i = 0; i < tobp_pkg::NAME_LIMIT; i++)
            add_byte(8'h78, 1'b0);
        add_byte(tobp_pkg::BYTE_NUL, 1'b0);
        add_byte(8'h00, 1'b1);
        // Accumulation stops at the first non-octal byte of the mode.
        add_text("12x34 b");
        add_byte(tobp_pkg::BYTE_NUL, 1'b0);
        add_hash(1'b1);
        // Two entries, the second with an empty mode and an empty name.
        add_text("40000 d");
        add_byte(tobp_pkg::BYTE_NUL, 1'b0);
        add_hash(1'b0);
        add_text(" ");
        add_byte(tobp_pkg::BYTE_NUL, 1'b0);
        add_hash(1'b1);
        // Truncation inside the hash, on a name end and on a name byte.
        add_text("644 t");
        add_byte(tobp_pkg::BYTE_NUL, 1'b0);
        for (int i = 0; i < 10; i++)
            add_byte(tobp_pkg::IN_DATA_W'($urandom_range(0, 255)), i == 9);
        add_text("7 n");
        add_byte(tobp_pkg::BYTE_NUL, 1'b1);
        add_text("7 n");
        add_byte(8'h6D, 1'b1);

        // Random objects up to the item budget: mostly well formed, some truncated,
        // some noise.
        while (pending_bytes.size() < TOTAL_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel <= 6) begin
                n = $urandom_range(1, 3);
                for (int e = 0; e < n; e++)
                    add_entry($urandom_range(0, 7), $urandom_range(0, 3) != 0,
                              ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                          : $urandom_range(0, 12),
                              e == n - 1);
            end else if (sel <= 8) begin
                mark = pending_bytes.size();
                n = $urandom_range(1, 2);
                for (int e = 0; e < n; e++)
                    add_entry($urandom_range(0, 7), 1'b1, $urandom_range(0, 8), 1'b0);
                cut = $urandom_range(mark, pending_bytes.size() - 1);
                pending_bytes[cut].fin = 1'b1;
                while (pending_bytes.size() > cut + 1)
                    void'(pending_bytes.pop_back());
            end else begin
                n = $urandom_range(1, 24);
                for (int i = 0; i < n; i++)
                    add_byte(tobp_pkg::IN_DATA_W'($urandom_range(0, 255)),
                             (i == n - 1) || ($urandom_range(0, 7) == 0));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_bytes.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Byte sender: bursts of random length separated by random gaps.
    int tx_burst_left = 0;
    int tx_gap_left   = 0;

    always @(posedge i_clk) begin : byte_sender
        t_byte_req req;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                parse_byte(i_s_axis_tdata, i_s_axis_tlast);
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    req = pending_bytes.pop_front();
                    i_s_axis_tdata  <= req.data;
                    i_s_axis_tlast  <= req.fin;
                    i_s_axis_tvalid <= 1'b1;
                    if (tx_burst_left > 0) begin
                        tx_burst_left--;
                    end else begin
                        tx_burst_left = $urandom_range(1, 48);
                        tx_gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: stall pattern changes per segment, with a long hold-off now and then.
    int rx_cycles    = 0;
    int rx_hold_left = 0;
    int rx_seg_left  = 0;
    int rx_mode      = 0;

    always @(posedge i_clk) begin : result_receiver
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles % 1000 == 200)
                rx_hold_left = 300 + $urandom_range(0, 200);
            if (rx_seg_left == 0) begin
                rx_mode     = $urandom_range(0, 3);
                rx_seg_left = $urandom_range(10, 200);
            end else begin
                rx_seg_left--;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       i_m_axis_tready <= 1'b1;
                    1:       i_m_axis_tready <= ($urandom_range(0, 1) == 0);
                    2:       i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest expectation, field by field.
    always @(posedge i_clk) begin : result_monitor
        tobp_pkg::t_result seen;
        tobp_pkg::t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen.kind          = o_m_axis_tuser;
            seen.entry_number  = o_m_axis_tdata[ENT_LSB +: tobp_pkg::ENTRY_NUM_W];
            seen.byte_offset   = o_m_axis_tdata[OFF_LSB +: tobp_pkg::OFFSET_W];
            seen.payload       = o_m_axis_tdata[PAY_LSB +: tobp_pkg::PAYLOAD_W];
            seen.mode_value    = o_m_axis_tdata[MODE_LSB +: tobp_pkg::MODE_W];
            seen.entries_total = o_m_axis_tdata[TOT_LSB +: tobp_pkg::TOTAL_W];
            seen.run_end       = o_m_axis_tlast;
            if (expected_results.size() == 0) begin
                report_mismatch("result with none pending, kind",
                                tobp_pkg::MODE_W'(seen.kind), '0);
            end else begin
                want = expected_results.pop_front();
                if (seen.kind !== want.kind)
                    report_mismatch("kind", tobp_pkg::MODE_W'(seen.kind),
                                    tobp_pkg::MODE_W'(want.kind));
                if (seen.entry_number !== want.entry_number)
                    report_mismatch("entry_number", tobp_pkg::MODE_W'(seen.entry_number),
                                    tobp_pkg::MODE_W'(want.entry_number));
                if (seen.byte_offset !== want.byte_offset)
                    report_mismatch("byte_offset", tobp_pkg::MODE_W'(seen.byte_offset),
                                    tobp_pkg::MODE_W'(want.byte_offset));
                if (seen.payload !== want.payload)
                    report_mismatch("payload", tobp_pkg::MODE_W'(seen.payload),
                                    tobp_pkg::MODE_W'(want.payload));
                if (seen.mode_value !== want.mode_value)
                    report_mismatch("mode_value", seen.mode_value, want.mode_value);
                if (seen.entries_total !== want.entries_total)
                    report_mismatch("entries_total", tobp_pkg::MODE_W'(seen.entries_total),
                                    tobp_pkg::MODE_W'(want.entries_total));
                if (seen.run_end !== want.run_end)
                    report_mismatch("run_end", tobp_pkg::MODE_W'(seen.run_end),
                                    tobp_pkg::MODE_W'(want.run_end));
            end
            if (o_m_axis_tdata[tobp_pkg::OUT_DATA_W-1:tobp_pkg::OUT_FIELD_W] !== '0)
                report_mismatch("tdata padding",
                    tobp_pkg::MODE_W'(o_m_axis_tdata[tobp_pkg::OUT_DATA_W-1:
                                                     tobp_pkg::OUT_FIELD_W]),
                    '0);
            results_seen++;
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin : run_watchdog
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

// ===== tree_object_byte_parser_top.f =====
rtl/core/tobp_pkg.sv
rtl/core/tree_object_byte_parser_top.sv
rtl/core/tobp_checker.sv
sim/tb_tree_object_byte_parser_top.sv
